/* hw/rtl/merge_sort_engine_macros.svh */
// Assertion macros shared by the merge sort engine.
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH

// Checks that an antecedent implies a consequent in the next cycle.
`define MSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define MSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;
	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam int VW = 31;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          is_last;
	} in_item_t;

	typedef struct packed {
		logic          stored;
		logic [AW-1:0] addr;
		logic [VW-1:0] value;
		logic          is_last;
	} cmd_t;
endpackage

/* hw/rtl/mse_ram.sv */
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hw/rtl/mse_front.sv */
// ----------------------------------------------------------------------------
// mse_front
// Accepts items, assigns store addresses, flags drops, and queues commands.
// ----------------------------------------------------------------------------
module mse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mse_pkg::in_item_t in_item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output mse_pkg::cmd_t     cmd
);
	import mse_pkg::*;

	logic [CW-1:0] count_q;
	cmd_t          q_q [QDEPTH];
	logic [1:0]    fill_q;
	logic          rd_q;
	logic          push, pop;
	cmd_t          nc;

	assign in_ready  = (fill_q != 2'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_q[rd_q];

	always_comb begin
		nc.stored  = (count_q < CW'(CAPACITY));
		nc.addr    = count_q[AW-1:0];
		nc.value   = in_item.value;
		nc.is_last = in_item.is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fill_q  <= '0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				q_q[rd_q ^ (fill_q != 2'd0) ^ (pop ? 1'b0 : 1'b0)] <= nc;
				if (nc.is_last) begin
					count_q <= '0;
				end else if (nc.stored) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* hw/rtl/mse_back.sv */
// ----------------------------------------------------------------------------
// mse_back
// Stores commands, runs bottom-up merge passes between two RAMs, and emits.
// ----------------------------------------------------------------------------
module mse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  mse_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_data,
	output logic          out_last,
	output logic          out_busy
);
	import mse_pkg::*;

	typedef enum logic [2:0] {LOAD, MSTART, MREQ, MLAT, MWR, EREQ, EWAIT, EOUT} st_t;

	st_t           st_q;
	logic [CW-1:0] n_q, w_q, lo_q, a_q, b_q, mid_q, hi_q, k_q;
	logic          side_q, first_q;
	logic [VW-1:0] va_q, vb_q;
	logic          rw_a_q;

	logic          we0, we1;
	logic [AW-1:0] wa0, wa1, ra0, ra1;
	logic [VW-1:0] wd0, wd1, rd0, rd1, rdx;
	logic [CW-1:0] ld_idx;
	logic [CW:0]   mid_w, hi_w;
	logic          take_a;

	mse_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram0 (
		.clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr(ra0), .rdata(rd0));
	mse_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram1 (
		.clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(ra1), .rdata(rd1));

	// Source RAM is side_q; destination is the other one.
	assign rdx = side_q ? rd1 : rd0;
	assign cmd_ready = (st_q == LOAD);
	assign out_busy = (st_q != LOAD);

	always_comb begin
		ld_idx = rw_a_q ? a_q : b_q;
		mid_w = (CW+1)'(lo_q) + (CW+1)'(w_q);
		hi_w  = (CW+1)'(lo_q) + (CW+1)'({w_q, 1'b0});
		take_a = (a_q < mid_q) && (!(b_q < hi_q) || (va_q <= vb_q));
		we0 = 1'b0; we1 = 1'b0;
		wa0 = k_q[AW-1:0]; wa1 = k_q[AW-1:0];
		wd0 = '0; wd1 = '0;
		ra0 = ld_idx[AW-1:0]; ra1 = ld_idx[AW-1:0];
		if (st_q == LOAD) begin
			we0 = cmd_valid && cmd.stored;
			wa0 = cmd.addr;
			wd0 = cmd.value;
		end else if (st_q == MWR) begin
			if (side_q) begin
				we0 = 1'b1;
				wd0 = take_a ? va_q : vb_q;
			end else begin
				we1 = 1'b1;
				wd1 = take_a ? va_q : vb_q;
			end
		end
		if (st_q == EREQ || st_q == EWAIT || st_q == EOUT) begin
			ra0 = k_q[AW-1:0]; ra1 = k_q[AW-1:0];
		end
	end

	// The heads of both runs are held in va_q and vb_q. Each MWR writes the
	// smaller head (the left one on ties), and the taken side, while its run
	// has values left, is refilled by a read in MREQ whose data is captured in MLAT.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LOAD; n_q <= '0; side_q <= 1'b0;
			w_q <= '0; lo_q <= '0; a_q <= '0; b_q <= '0; mid_q <= '0; hi_q <= '0;
			k_q <= '0; first_q <= 1'b0; rw_a_q <= 1'b0; va_q <= '0; vb_q <= '0;
			out_valid <= 1'b0; out_data <= '0; out_last <= 1'b0;
		end else begin
			case (st_q)
				LOAD: begin
					if (cmd_valid) begin
						if (cmd.stored) n_q <= n_q + 1'b1;
						if (cmd.is_last) begin
							side_q <= 1'b0;
							w_q <= CW'(1);
							lo_q <= '0;
							st_q <= MSTART;
						end
					end
				end
				MSTART: begin
					if (w_q >= n_q) begin
						k_q <= '0;
						st_q <= EREQ;
					end else if (lo_q >= n_q) begin
						side_q <= ~side_q;
						w_q <= {w_q[CW-2:0], 1'b0};
						lo_q <= '0;
					end else begin
						a_q <= lo_q;
						k_q <= lo_q;
						mid_q <= (mid_w > (CW+1)'(n_q)) ? n_q : mid_w[CW-1:0];
						hi_q <= (hi_w > (CW+1)'(n_q)) ? n_q : hi_w[CW-1:0];
						b_q <= (mid_w > (CW+1)'(n_q)) ? n_q : mid_w[CW-1:0];
						rw_a_q <= 1'b1;
						first_q <= 1'b1;
						st_q <= MREQ;
					end
				end
				MREQ: st_q <= MLAT;
				MLAT: begin
					if (rw_a_q) va_q <= rdx; else vb_q <= rdx;
					first_q <= 1'b0;
					if (first_q && (b_q < hi_q)) begin
						rw_a_q <= 1'b0;
						st_q <= MREQ;
					end else begin
						st_q <= MWR;
					end
				end
				MWR: begin
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 >= hi_q) begin
						lo_q <= hi_q;
						st_q <= MSTART;
					end else if (take_a) begin
						a_q <= a_q + 1'b1;
						if (a_q + 1'b1 < mid_q) begin
							rw_a_q <= 1'b1;
							st_q <= MREQ;
						end else begin
							st_q <= MWR;
						end
					end else begin
						b_q <= b_q + 1'b1;
						if (b_q + 1'b1 < hi_q) begin
							rw_a_q <= 1'b0;
							st_q <= MREQ;
						end else begin
							st_q <= MWR;
						end
					end
				end
				EREQ: st_q <= EWAIT;
				EWAIT: begin
					out_valid <= 1'b1;
					out_data <= {1'b0, rdx};
					out_last <= (k_q + 1'b1 == n_q);
					st_q <= EOUT;
				end
				EOUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (k_q + 1'b1 == n_q) begin
							n_q <= '0; st_q <= LOAD;
						end else begin
							k_q <= k_q + 1'b1; st_q <= EREQ;
						end
					end
				end
				default: st_q <= LOAD;
			endcase
		end
	end
endmodule

/* hw/rtl/merge_sort_engine.sv */
// An accepted item passes through the command queue and is written to the store
// while the back end is loading. Throughput while loading is one item per cycle. A
// last item starts a sort of n values by the single-read merge loop; emission then
// outputs one value at a time, reading the next only after the last one is taken.
// Reset: arst_n clears the queue, counters and state; store contents are undefined.
// ----------------------------------------------------------------------------
// merge_sort_engine
// Stream-in, sort, stream-out engine using a stable bottom-up merge sort.
// ----------------------------------------------------------------------------
module merge_sort_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value[30:0]
	input  logic        s_axis_tlast,  // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // sorted_value[30:0]
	output logic        m_axis_tlast,  // end_of_run
	output logic        m_axis_tuser   // overflowed
);
	import mse_pkg::*;
`include "merge_sort_engine_macros.svh"

	in_item_t in_item;
	cmd_t     cmd;
	logic     cmd_valid, cmd_ready, busy, drop_q, last_raw;

	assign in_item.value   = s_axis_tdata[VW-1:0];
	assign in_item.is_last = s_axis_tlast;

	mse_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_item(in_item), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

	mse_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_last(last_raw), .out_busy(busy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cmd_valid && cmd_ready && !cmd.stored) begin
			drop_q <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready && last_raw) begin
			drop_q <= 1'b0;
		end
	end

	assign m_axis_tlast = last_raw;
	assign m_axis_tuser = last_raw && drop_q;

	`MSE_ASSERT_NOW(a_out_only_busy, m_axis_tvalid, busy)
	`MSE_ASSERT_NOW(a_no_cmd_while_busy, busy, !cmd_ready)
	`MSE_ASSERT_NEXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
endmodule

/* sim/tb_merge_sort_engine.sv */
// ----------------------------------------------------------------------------
// tb_merge_sort_engine
// Streams sets of values into the sort engine and checks the sorted items
// that come back, in order, against directed rows and a predictor kept in the testbench.
// ----------------------------------------------------------------------------
module tb_merge_sort_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import mse_pkg::*;

	typedef struct {
		logic [VW-1:0] value;
		logic          is_last;
	} set_item_t;

	typedef struct {
		logic [VW-1:0] value;
		logic          end_flag;
		logic          over_flag;
	} sorted_item_t;

	localparam int LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	merge_sort_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	logic [VW-1:0] held_values[$];
	logic          set_dropped;
	sorted_item_t  sorted_expect[$];
	set_item_t     stim[$];
	int            errors;
	int            reported;
	int            cycles;
	int            send_idle;
	int            recv_idle;
	bit            recv_hold;

	// Directed rows: exact sorted items typed in.
	task automatic push_exact(input logic [VW-1:0] v, input logic e, input logic o);
		sorted_item_t r;
		r.value = v;
		r.end_flag = e;
		r.over_flag = o;
		sorted_expect = {sorted_expect, r};
	endtask

	// Stable merge sort of the held set; equal values keep their order.
	task automatic sort_held_set();
		logic [VW-1:0] src[$];
		logic [VW-1:0] dst[$];
		int n;
		int w;
		int lo;
		int a;
		int b;
		int mid;
		int hi;
		src = held_values;
		n = src.size();
		for (w = 1; w < n; w = w * 2) begin
			dst = {};
			for (lo = 0; lo < n; lo = lo + 2 * w) begin
				mid = (lo + w > n) ? n : lo + w;
				hi = (lo + 2 * w > n) ? n : lo + 2 * w;
				a = lo;
				b = mid;
				while (a < mid || b < hi) begin
					if (b >= hi || (a < mid && src[a] <= src[b])) begin
						dst = {dst, src[a]};
						a++;
					end else begin
						dst = {dst, src[b]};
						b++;
					end
				end
			end
			src = dst;
		end
		held_values = src;
	endtask

	task automatic predict_item(input set_item_t it);
		sorted_item_t r;
		int i;
		if (held_values.size() < CAPACITY)
			held_values = {held_values, it.value};
		else
			set_dropped = 1'b1;
		if (it.is_last) begin
			sort_held_set();
			for (i = 0; i < held_values.size(); i++) begin
				r.value = held_values[i];
				r.end_flag = (i == held_values.size() - 1);
				r.over_flag = r.end_flag ? set_dropped : 1'b0;
				sorted_expect = {sorted_expect, r};
			end
			held_values = {};
			set_dropped = 1'b0;
		end
	endtask

	function automatic set_item_t mk(input logic [VW-1:0] v, input logic l);
		set_item_t s;
		s.value = v;
		s.is_last = l;
		return s;
	endfunction

	task automatic add_random_set(input int n, input int span);
		int i;
		logic [VW-1:0] v;
		for (i = 0; i < n; i++) begin
			if (span == 0)
				v = VW'({$urandom} & 32'h7fff_ffff);
			else
				v = VW'($urandom_range(span, 1));
			stim = {stim, mk(v, i == n - 1)};
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("merge_sort_engine regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		sorted_item_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sorted_expect.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected item: data %h last %b user %b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end
			end else begin
				e = sorted_expect.pop_front();
				if (m_axis_tdata !== {1'b0, e.value} || m_axis_tlast !== e.end_flag ||
						m_axis_tuser !== e.over_flag) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("mismatch: expected %h/%b/%b actual %h/%b/%b",
							e.value, e.end_flag, e.over_flag,
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (recv_hold)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99, 0) >= recv_idle);
	end

	initial begin
		int i;
		int k;
		int phase;
		int sent;
		int directed;
		errors = 0;
		reported = 0;
		cycles = 0;
		set_dropped = 1'b0;
		send_idle = 25;
		recv_idle = 74;
		recv_hold = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a one-item set, extremes, ties, zero, and a reversed set.
		stim = {stim, mk(31'h7fff_ffff, 1'b1)};
		push_exact(31'h7fff_ffff, 1'b1, 1'b0);
		stim = {stim, mk(31'h7fff_ffff, 1'b0)};
		stim = {stim, mk(31'd1, 1'b0)};
		stim = {stim, mk(31'd0, 1'b0)};
		stim = {stim, mk(31'h5555_5555, 1'b0)};
		stim = {stim, mk(31'h2aaa_aaaa, 1'b0)};
		stim = {stim, mk(31'd1, 1'b1)};
		push_exact(31'd0, 1'b0, 1'b0);
		push_exact(31'd1, 1'b0, 1'b0);
		push_exact(31'd1, 1'b0, 1'b0);
		push_exact(31'h2aaa_aaaa, 1'b0, 1'b0);
		push_exact(31'h5555_5555, 1'b0, 1'b0);
		push_exact(31'h7fff_ffff, 1'b1, 1'b0);
		for (i = 0; i < 8; i++)
			stim = {stim, mk(VW'(8 - i), i == 7)};
		for (i = 1; i <= 8; i++)
			push_exact(VW'(i), i == 8, 1'b0);
		directed = stim.size();

		for (phase = 0; phase < 3; phase++) begin
			if (phase == 0) begin
				// Overflow set: 70 items, capacity 64.
				add_random_set(CAPACITY + 6, 0);
				for (k = 0; k < 4; k++)
					add_random_set($urandom_range(12, 1), (k % 2) ? 8 : 0);
			end else if (phase == 1) begin
				add_random_set(CAPACITY, 0);
				for (k = 0; k < 5; k++)
					add_random_set($urandom_range(10, 1), (k % 3 == 0) ? 4 : 0);
			end else begin
				for (k = 0; k < 8; k++)
					add_random_set($urandom_range(6, 1), (k % 2) ? 3 : 0);
			end
			sent = 0;
			while (stim.size() > 0) begin
				set_item_t it;
				it = stim.pop_front();
				if (phase > 0 || sent >= directed)
					predict_item(it);
				@(negedge clk);
				while ($urandom_range(99, 0) < send_idle) begin
					s_axis_tvalid <= 1'b0;
					@(negedge clk);
				end
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {1'b0, it.value};
				s_axis_tlast <= it.is_last;
				@(posedge clk);
				while (!s_axis_tready)
					@(posedge clk);
				sent++;
				if (phase == 1 && sent == 20) begin
					recv_hold = 1'b1;
					fork
						begin
							repeat (3000) @(posedge clk);
							recv_hold = 1'b0;
						end
					join_none
				end
			end
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tlast <= 1'b0;
			while (sorted_expect.size() > 0 || recv_hold)
				@(posedge clk);
			send_idle = (phase == 0) ? 74 : 0;
			recv_idle = (phase == 0) ? 25 : 0;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && sorted_expect.size() == 0)
			$display("merge_sort_engine regression: pass");
		else
			$display("merge_sort_engine regression: fail");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/mse_front.sv
hw/rtl/mse_back.sv
hw/rtl/merge_sort_engine.sv
sim/tb_merge_sort_engine.sv
